FILE: hdl/cgrr_pkg.sv
// Package for the consumer group round-robin dispatcher.
// Holds the command and status codes, the controller states and the probe
// record that walks the row of member cells. No dependencies.
package cgrr_pkg;

    // Widest slot index the member table may ever need (64 slots)
    localparam int SLOT_MAX_W = 6;

    // Field widths of the streaming items
    localparam int CMD_W    = 2;
    localparam int ID_W     = 32;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 3;
    localparam int OSLOT_W  = 3;
    localparam int OCOUNT_W = 4;
    localparam int TOTAL_W  = 64;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 144;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_DISPATCH = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_DUP      = 3'd1,
        STS_FULL     = 3'd2,
        STS_NOTFOUND = 3'd3,
        STS_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Search record handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic                  valid;
        logic [ID_W-1:0]       key;
        logic                  hit;
        logic [SLOT_MAX_W-1:0] hit_slot;
        logic [ID_W-1:0]       last_id;
        logic [ID_W-1:0]       ptr_id;
    } probe_t;

endpackage

FILE: hdl/cgrr_cell.sv
// One slot of the member table: stores a member id and updates the probe
// record passing through it. Depends on cgrr_pkg.
module cgrr_cell #(
    parameter int IDX    = 0,
    parameter int CNT_W  = 4,
    parameter int SLOT_W = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CNT_W-1:0]     count,
    input  logic [SLOT_W-1:0]    sel,
    input  logic                 wr_en,
    input  logic [31:0]          wr_data,
    input  cgrr_pkg::probe_t     probe_in,
    output cgrr_pkg::probe_t     probe_out
);
    import cgrr_pkg::*;

    logic [ID_W-1:0] id_reg;
    probe_t          probe_reg;
    probe_t          probe_next;
    logic            occupied;

    assign occupied = CNT_W'(IDX) < count;

    // Compare the key, pick up the last entry and the entry at the pointer
    always_comb begin
        probe_next = probe_in;
        if (occupied && !probe_in.hit && (id_reg == probe_in.key)) begin
            probe_next.hit      = 1'b1;
            probe_next.hit_slot = SLOT_MAX_W'(IDX);
        end
        if (CNT_W'(IDX + 1) == count) begin
            probe_next.last_id = id_reg;
        end
        if (SLOT_W'(IDX) == sel) begin
            probe_next.ptr_id = id_reg;
        end
    end

    // Hold the stored id until written
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_reg <= wr_data;
        end
    end

    // Advance the probe one cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg.valid <= probe_next.valid;
        end
        probe_reg.key      <= probe_next.key;
        probe_reg.hit      <= probe_next.hit;
        probe_reg.hit_slot <= probe_next.hit_slot;
        probe_reg.last_id  <= probe_next.last_id;
        probe_reg.ptr_id   <= probe_next.ptr_id;
    end

    assign probe_out = probe_reg;

endmodule

FILE: hdl/consumer_group_round_robin_core.sv
// Top level of the consumer group round-robin dispatcher.
// Controller, state registers and the row of cgrr_cell slots.
// Depends on cgrr_pkg and cgrr_cell.
//
// Usage:
//   The s_ channel takes one command item: add a member id, remove a member
//   id, or dispatch one message tag. The m_ channel returns exactly one result
//   item per command, in order: status, chosen member id and slot, forwarded
//   tag, member count after the command and the running dispatch total.
//   Each command launches a probe through a chain of MAX_CONSUMERS cells, one
//   cell per cycle; the probe collects the duplicate/lookup hit, the last
//   entry and the entry under the round-robin pointer. The probe result is
//   registered, and the table, count and pointer are updated when the result
//   is loaded into the output register. One command is in flight at a time,
//   so a new item is not taken until the previous result has been loaded.
//   The result sits in an output register; s_tready rises again as soon as
//   the result is loaded, even while m_tready is low. If the receiver stalls,
//   the next command completes its scan and then waits until the output
//   register is free. Reset clears the count, pointer, dispatch total and all
//   handshake state; the stored ids are not cleared and are never read before
//   being written.
module consumer_group_round_robin_core #(
    parameter int MAX_CONSUMERS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] cmd, [33:2] member_id, [65:34] message_tag, rest zero
    input  logic [cgrr_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [34:3] target_id, [37:35] target_slot, [69:38] tag_out,
    // [73:70] member_count, [137:74] dispatched_total, rest zero
    output logic [cgrr_pkg::M_DATA_W-1:0]   m_tdata
);
    import cgrr_pkg::*;

    localparam int SLOT_W = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
    localparam int CNT_W  = $clog2(MAX_CONSUMERS + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SLOT_W-1:0]    ptr_reg, ptr_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    cmd_t                 cmd_reg;
    logic [TAG_W-1:0]     tag_reg;
    probe_t               res_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    probe_t               probe_w [0:MAX_CONSUMERS];
    logic [SLOT_W-1:0]    sel;
    logic                 s_fire;
    logic                 out_free;
    logic                 done_fire;
    logic                 capture;
    logic                 table_we;
    logic [SLOT_W-1:0]    wr_slot;
    logic [ID_W-1:0]      wr_data;

    // Dispatch slot: the pointer, or slot 0 if it ever lies past the end
    assign sel = (CNT_W'(ptr_reg) < cnt_reg) ? ptr_reg : '0;

    // Launch a probe into the first cell on accept
    assign s_fire = s_tvalid && s_tready;
    always_comb begin
        probe_w[0]          = '0;
        probe_w[0].valid    = s_fire;
        probe_w[0].key      = s_tdata[33:2];
    end

    // Row of member cells
    for (genvar i = 0; i < MAX_CONSUMERS; i++) begin : g_cell
        cgrr_cell #(
            .IDX    (i),
            .CNT_W  (CNT_W),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .count     (cnt_reg),
            .sel       (sel),
            .wr_en     (table_we && (wr_slot == SLOT_W'(i))),
            .wr_data   (wr_data),
            .probe_in  (probe_w[i]),
            .probe_out (probe_w[i+1])
        );
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_SCAN;
            ST_SCAN: if (probe_w[MAX_CONSUMERS].valid) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State machine outputs
    assign out_free = !m_tvalid_reg || m_tready;
    always_comb begin
        s_tready  = 1'b0;
        capture   = 1'b0;
        done_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_SCAN: capture   = probe_w[MAX_CONSUMERS].valid;
            ST_DONE: done_fire = out_free;
            default: ;
        endcase
    end

    // Decide the command outcome and the state updates
    always_comb begin
        status_t          sts;
        logic [ID_W-1:0]  tgt_id;
        logic [OSLOT_W-1:0] tgt_slot;
        logic [TAG_W-1:0] tag_o;
        logic [SLOT_W-1:0] hslot;
        logic [SLOT_W-1:0] p;
        logic [CNT_W-1:0]  c;

        sts        = STS_OK;
        tgt_id     = '0;
        tgt_slot   = '0;
        tag_o      = '0;
        hslot      = SLOT_W'(res_reg.hit_slot);
        p          = ptr_reg;
        c          = cnt_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        total_next = total_reg;
        table_we   = 1'b0;
        wr_slot    = '0;
        wr_data    = res_reg.key;

        unique case (cmd_reg)
            CMD_ADD: begin
                if (res_reg.hit) begin
                    sts = STS_DUP;
                end else if (cnt_reg >= CNT_W'(MAX_CONSUMERS)) begin
                    sts = STS_FULL;
                end else begin
                    table_we = done_fire;
                    wr_slot  = SLOT_W'(cnt_reg);
                    wr_data  = res_reg.key;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!res_reg.hit) begin
                    sts = STS_NOTFOUND;
                end else begin
                    table_we = done_fire;
                    wr_slot  = hslot;
                    wr_data  = res_reg.last_id;
                    if (hslot < ptr_reg) p = ptr_reg - 1'b1;
                    c        = cnt_reg - 1'b1;
                    cnt_next = c;
                    if ((c == '0) || (CNT_W'(p) >= c)) p = '0;
                    ptr_next = p;
                end
            end
            CMD_DISPATCH: begin
                if (cnt_reg == '0) begin
                    sts = STS_EMPTY;
                end else begin
                    tgt_id     = res_reg.ptr_id;
                    tgt_slot   = OSLOT_W'(sel);
                    tag_o      = tag_reg;
                    ptr_next   = (CNT_W'(sel) + 1'b1 == cnt_reg) ? '0 : sel + 1'b1;
                    total_next = total_reg + 1'b1;
                end
            end
            CMD_NOP: ;
            default: ;
        endcase

        m_tdata_next           = '0;
        m_tdata_next[2:0]      = sts;
        m_tdata_next[34:3]     = tgt_id;
        m_tdata_next[37:35]    = tgt_slot;
        m_tdata_next[69:38]    = tag_o;
        m_tdata_next[73:70]    = OCOUNT_W'(cnt_next);
        m_tdata_next[137:74]   = total_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (done_fire) begin
                cnt_reg   <= cnt_next;
                ptr_reg   <= ptr_next;
                total_reg <= total_next;
            end
            if (done_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= cmd_t'(s_tdata[1:0]);
            tag_reg <= s_tdata[65:34];
        end
        if (capture) begin
            res_reg <= probe_w[MAX_CONSUMERS];
        end
        if (done_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Member count never exceeds the table size
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_CONSUMERS))
        else $error("member count above table size");

    // Pointer stays inside the occupied slots, and at 0 on an empty table
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) ? (ptr_reg == '0) : (CNT_W'(ptr_reg) < cnt_reg))
        else $error("round-robin pointer out of range");

    // A probe leaves the chain only while the controller waits for it
    a_tail_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        probe_w[MAX_CONSUMERS].valid |-> (state_reg == ST_SCAN))
        else $error("probe left chain outside scan");

    // A successful dispatch bumps the total by exactly one
    a_total_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_fire && (cmd_reg == CMD_DISPATCH) && (cnt_reg != '0))
        |=> (total_reg == $past(total_reg) + 1'b1))
        else $error("dispatch total did not advance");

endmodule
